>>> src/scbs_pkg.sv
// Shared constants, codes and the frame length table of the command block scanner.
`default_nettype none
package scbs_pkg;

    // Command RAM geometry
    localparam int RAM_BYTES = 64;
    localparam int ADDR_W    = 6;
    localparam int IDX_W     = 7;
    localparam int DATA_W    = 8;

    // Results per scan, closing result included
    localparam int MAX_RESULTS = 12;
    localparam int CNT_W       = 4;

    // Special bytes of the command block
    localparam logic [7:0] BYTE_END     = 8'hFE;
    localparam logic [7:0] BYTE_PAD     = 8'hFF;
    localparam logic [7:0] BYTE_PAD_ALT = 8'hFD;
    localparam logic [7:0] BYTE_SKIP    = 8'h00;

    // Input item codes
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_SCAN  = 1'b1;

    // Scan modes
    localparam logic MODE_INPUT  = 1'b0;
    localparam logic MODE_OUTPUT = 1'b1;

    // Result status codes
    localparam logic [1:0] ST_FRAME   = 2'd0;
    localparam logic [1:0] ST_END     = 2'd1;
    localparam logic [1:0] ST_UNKNOWN = 2'd2;
    localparam logic [1:0] ST_OVERRUN = 2'd3;

    // Command codes
    localparam logic [7:0] CB_INFO     = 8'h00;
    localparam logic [7:0] CB_READ     = 8'h01;
    localparam logic [7:0] CB_PAK_RD   = 8'h02;
    localparam logic [7:0] CB_PAK_WR   = 8'h03;
    localparam logic [7:0] CB_EEP_RD   = 8'h04;
    localparam logic [7:0] CB_EEP_WR   = 8'h05;
    localparam logic [7:0] CB_STATUS   = 8'h06;
    localparam logic [7:0] CB_RTC_RD   = 8'h07;
    localparam logic [7:0] CB_RTC_WR   = 8'h08;
    localparam logic [7:0] CB_RESET    = 8'hFF;

    // Frame lengths after the command offset
    localparam logic [IDX_W-1:0] LEN_SHORT = 7'd4;
    localparam logic [IDX_W-1:0] LEN_READ  = 7'd5;
    localparam logic [IDX_W-1:0] LEN_PAK   = 7'h24;
    localparam logic [IDX_W-1:0] LEN_EEP   = 7'hA;
    localparam logic [IDX_W-1:0] LEN_RTC   = 7'hB;
    localparam logic [IDX_W-1:0] LEN_NONE  = 7'd0;

    // Frame length of a command, zero for unknown or reserved codes
    function automatic logic [IDX_W-1:0] frame_len(input logic [7:0] cb);
        logic [IDX_W-1:0] len;
        case (cb)
            CB_RESET, CB_INFO, CB_STATUS: len = LEN_SHORT;
            CB_READ:                      len = LEN_READ;
            CB_PAK_RD, CB_PAK_WR:         len = LEN_PAK;
            CB_EEP_RD, CB_EEP_WR:         len = LEN_EEP;
            CB_RTC_RD, CB_RTC_WR:         len = LEN_RTC;
            default:                      len = LEN_NONE;
        endcase
        return len;
    endfunction

endpackage
`default_nettype wire

>>> src/scbs_ram.sv
// Generic single-port-write, registered-read RAM.
`default_nettype none
module scbs_ram #(
    parameter int WIDTH = scbs_pkg::DATA_W,
    parameter int DEPTH = scbs_pkg::RAM_BYTES
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write and read, read data registered
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

>>> src/serial_command_block_scanner_core.sv
// Command block scanner: command RAM, byte-walk sequencer and result register.
// Usage:
//   Input channel (in_valid/in_ready, cmd, byte_index, byte_value): a write
//   request (cmd 0) stores one byte of the 64-byte command RAM; writes
//   stream at one per cycle while no scan runs. A scan request (cmd 1) walks the
//   RAM from offset 0; in_ready stays low until its closing result is loaded.
//   Output channel (out_valid/out_ready): one descriptor per frame found,
//   then one closing result with last set; at most 12 results per scan.
//   Scan walk: the walk reads the RAM through its registered read port.
//   With the receiver ready, the longest scan is a block of zero bytes.
//   Configuration channel (cfg_valid/cfg_ready, cfg_data): writes scan_mode,
//   always ready; write it only between scans.
//   Reset: all RAM bytes read as zero (per-byte valid flags are cleared),
//   scan_mode is 0 and no result is pending.
//   Receiver stall: a held result stops the walk at its next result; write
//   requests are still taken while a closing result waits in the output register.
`default_nettype none
module serial_command_block_scanner_core (
    input  wire logic       clk,
    input  wire logic       rst_n,
    // input requests
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic       cmd,
    input  wire logic [5:0] byte_index,
    input  wire logic [7:0] byte_value,
    // configuration writes
    input  wire logic       cfg_valid,
    output logic            cfg_ready,
    input  wire logic       cfg_data,
    // results
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic [5:0]      channel,
    output logic [7:0]      tx_byte,
    output logic [5:0]      rx_offset,
    output logic [7:0]      command_byte,
    output logic [5:0]      command_offset,
    output logic            execute,
    output logic [1:0]      status,
    output logic            last
);

    localparam int AW = scbs_pkg::ADDR_W;
    localparam int IW = scbs_pkg::IDX_W;
    localparam int DW = scbs_pkg::DATA_W;
    localparam int CW = scbs_pkg::CNT_W;

    localparam logic [IW-1:0] IDX_LAST  = IW'(scbs_pkg::RAM_BYTES - 1);
    localparam logic [IW-1:0] IDX_LIMIT = IW'(scbs_pkg::RAM_BYTES);
    localparam logic [IW-1:0] IDX_NEAR  = IW'(scbs_pkg::RAM_BYTES - 2);
    localparam logic [CW-1:0] CNT_FULL  = CW'(scbs_pkg::MAX_RESULTS - 1);
    localparam logic [AW-1:0] ADDR_LAST = AW'(scbs_pkg::RAM_BYTES - 1);

    // Sequencer states
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_TOP  = 3'd1;
    localparam logic [2:0] S_CHK0 = 3'd2;
    localparam logic [2:0] S_CHK1 = 3'd3;
    localparam logic [2:0] S_PAD  = 3'd4;
    localparam logic [2:0] S_CMD  = 3'd5;
    localparam logic [2:0] S_EMIT = 3'd6;

    logic [2:0]    state_reg, state_next;
    logic [IW-1:0] idx_reg, idx_next;
    logic [5:0]    ch_reg, ch_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [DW-1:0] tx_reg, tx_next;
    logic [AW-1:0] rxo_reg, rxo_next;
    logic [DW-1:0] cb_reg, cb_next;
    logic [AW-1:0] co_reg, co_next;
    logic          ex_reg, ex_next;
    logic [1:0]    st_reg, st_next;
    logic          lst_reg, lst_next;
    logic          mode_reg;

    logic [scbs_pkg::RAM_BYTES-1:0] valid_reg;
    logic          rdv_reg;
    logic [AW-1:0] rd_addr;
    logic [DW-1:0] ram_rdata;
    logic [DW-1:0] rd_byte;
    logic          ram_we;
    logic          out_free;
    logic          load_out;
    logic          clear_last;
    logic [IW-1:0] idx_p1;
    logic [IW-1:0] idx_p2;
    logic [IW-1:0] len;
    logic          is_pad;

    logic          out_valid_reg;
    logic [5:0]    channel_reg;
    logic [7:0]    tx_byte_reg;
    logic [5:0]    rx_offset_reg;
    logic [7:0]    command_byte_reg;
    logic [5:0]    command_offset_reg;
    logic          execute_reg;
    logic [1:0]    status_reg;
    logic          last_reg;

    scbs_ram #(
        .WIDTH(scbs_pkg::DATA_W),
        .DEPTH(scbs_pkg::RAM_BYTES)
    ) u_ram (
        .clk  (clk),
        .we   (ram_we),
        .waddr(byte_index),
        .wdata(byte_value),
        .raddr(rd_addr),
        .rdata(ram_rdata)
    );

    // Unwritten bytes read as zero
    assign rd_byte  = rdv_reg ? ram_rdata : '0;
    assign idx_p1   = idx_reg + IW'(1);
    assign idx_p2   = idx_reg + IW'(2);
    assign len      = scbs_pkg::frame_len(rd_byte);
    assign is_pad   = (rd_byte == scbs_pkg::BYTE_PAD) || (rd_byte == scbs_pkg::BYTE_PAD_ALT);
    assign out_free = !out_valid_reg || out_ready;

    assign in_ready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign ram_we    = in_valid && in_ready && (cmd == scbs_pkg::CMD_WRITE);
    assign load_out  = (state_reg == S_EMIT) && out_free;
    assign clear_last = load_out && lst_reg && (st_reg == scbs_pkg::ST_END);

    // Sequence the walk
    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        ch_next    = ch_reg;
        cnt_next   = cnt_reg;
        tx_next    = tx_reg;
        rxo_next   = rxo_reg;
        cb_next    = cb_reg;
        co_next    = co_reg;
        ex_next    = ex_reg;
        st_next    = st_reg;
        lst_next   = lst_reg;
        rd_addr    = idx_reg[AW-1:0];

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid && (cmd == scbs_pkg::CMD_SCAN))
                begin
                    idx_next   = '0;
                    ch_next    = '0;
                    cnt_next   = '0;
                    state_next = S_TOP;
                end
            end
            S_TOP:
            begin
                if (idx_reg >= IDX_LIMIT)
                begin
                    st_next    = scbs_pkg::ST_OVERRUN;
                    lst_next   = 1'b1;
                    state_next = S_EMIT;
                end
                else
                begin
                    rd_addr    = idx_reg[AW-1:0];
                    state_next = S_CHK0;
                end
            end
            S_CHK0:
            begin
                if (rd_byte == scbs_pkg::BYTE_END)
                begin
                    st_next    = scbs_pkg::ST_END;
                    lst_next   = 1'b1;
                    state_next = S_EMIT;
                end
                else if (idx_reg == IDX_LAST)
                begin
                    st_next    = scbs_pkg::ST_OVERRUN;
                    lst_next   = 1'b1;
                    state_next = S_EMIT;
                end
                else
                begin
                    rd_addr    = idx_p1[AW-1:0];
                    state_next = S_CHK1;
                end
            end
            S_CHK1:
            begin
                if (rd_byte == scbs_pkg::BYTE_END)
                begin
                    st_next    = scbs_pkg::ST_END;
                    lst_next   = 1'b1;
                    state_next = S_EMIT;
                end
                else
                begin
                    rd_addr    = idx_reg[AW-1:0];
                    state_next = S_PAD;
                end
            end
            S_PAD:
            begin
                if (is_pad)
                begin
                    // skip pad byte
                    idx_next = idx_p1;
                    if (idx_reg == IDX_LAST)
                    begin
                        st_next    = scbs_pkg::ST_OVERRUN;
                        lst_next   = 1'b1;
                        state_next = S_EMIT;
                    end
                    else
                    begin
                        rd_addr = idx_p1[AW-1:0];
                    end
                end
                else if (rd_byte == scbs_pkg::BYTE_END)
                begin
                    st_next    = scbs_pkg::ST_END;
                    lst_next   = 1'b1;
                    state_next = S_EMIT;
                end
                else if (rd_byte == scbs_pkg::BYTE_SKIP)
                begin
                    // empty channel: step past the byte and advance channel, no result
                    idx_next   = idx_p1;
                    ch_next    = ch_reg + 6'd1;
                    state_next = S_TOP;
                end
                else if (idx_reg >= IDX_NEAR)
                begin
                    idx_next   = idx_p1;
                    st_next    = scbs_pkg::ST_OVERRUN;
                    lst_next   = 1'b1;
                    state_next = S_EMIT;
                end
                else
                begin
                    tx_next    = rd_byte;
                    rxo_next   = idx_p1[AW-1:0];
                    co_next    = idx_p2[AW-1:0];
                    idx_next   = idx_p2;
                    rd_addr    = idx_p2[AW-1:0];
                    state_next = S_CMD;
                end
            end
            S_CMD:
            begin
                if (len == scbs_pkg::LEN_NONE)
                begin
                    cb_next    = rd_byte;
                    ex_next    = 1'b0;
                    st_next    = scbs_pkg::ST_UNKNOWN;
                    lst_next   = 1'b1;
                    state_next = S_EMIT;
                end
                else if (cnt_reg >= CNT_FULL)
                begin
                    st_next    = scbs_pkg::ST_OVERRUN;
                    lst_next   = 1'b1;
                    state_next = S_EMIT;
                end
                else
                begin
                    cb_next    = rd_byte;
                    ex_next    = (mode_reg == scbs_pkg::MODE_INPUT) ||
                                 (rd_byte == scbs_pkg::CB_READ);
                    st_next    = scbs_pkg::ST_FRAME;
                    lst_next   = 1'b0;
                    idx_next   = idx_reg + len;
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    if (lst_reg)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        ch_next    = ch_reg + 6'd1;
                        cnt_next   = cnt_reg + CW'(1);
                        state_next = S_TOP;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold sequencer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            mode_reg  <= scbs_pkg::MODE_INPUT;
            valid_reg <= '0;
            rdv_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            rdv_reg   <= valid_reg[rd_addr];
            if (cfg_valid && cfg_ready)
            begin
                mode_reg <= cfg_data;
            end
            if (ram_we)
            begin
                valid_reg[byte_index] <= 1'b1;
            end
            else if (clear_last)
            begin
                // normal end clears the last RAM byte's valid flag, so it reads as zero
                valid_reg[ADDR_LAST] <= 1'b0;
            end
        end
    end

    // Hold walk datapath
    always_ff @(posedge clk)
    begin
        idx_reg <= idx_next;
        ch_reg  <= ch_next;
        cnt_reg <= cnt_next;
        tx_reg  <= tx_next;
        rxo_reg <= rxo_next;
        cb_reg  <= cb_next;
        co_reg  <= co_next;
        ex_reg  <= ex_next;
        st_reg  <= st_next;
        lst_reg <= lst_next;
    end

    // Track the output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Load result; closing results on end or overrun carry only channel, status and last
    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            channel_reg <= ch_reg;
            status_reg  <= st_reg;
            last_reg    <= lst_reg;
            if (lst_reg && (st_reg != scbs_pkg::ST_UNKNOWN))
            begin
                tx_byte_reg        <= '0;
                rx_offset_reg      <= '0;
                command_byte_reg   <= '0;
                command_offset_reg <= '0;
                execute_reg        <= 1'b0;
            end
            else
            begin
                tx_byte_reg        <= tx_reg;
                rx_offset_reg      <= rxo_reg;
                command_byte_reg   <= cb_reg;
                command_offset_reg <= co_reg;
                execute_reg        <= ex_reg;
            end
        end
    end

    assign out_valid      = out_valid_reg;
    assign channel        = channel_reg;
    assign tx_byte        = tx_byte_reg;
    assign rx_offset      = rx_offset_reg;
    assign command_byte   = command_byte_reg;
    assign command_offset = command_offset_reg;
    assign execute        = execute_reg;
    assign status         = status_reg;
    assign last           = last_reg;

endmodule
`default_nettype wire

>>> test/tb_serial_command_block_scanner_core.sv
// Testbench for the command block scanner: byte loads and scans checked against a scan predictor.
`default_nettype none
module tb_serial_command_block_scanner_core;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT  = 2000000;
    localparam int SETTLE       = 8;
    localparam int HOLD_CYCLES  = 400;
    localparam int PHASE_ITEMS  = 78;
    // A code that no frame length covers
    localparam logic [7:0] CB_UNDEFINED = 8'h09;

    typedef struct {
        logic       cmd;
        logic [5:0] byte_index;
        logic [7:0] byte_value;
    } ram_request_t;

    typedef struct packed {
        logic [5:0] channel;
        logic [7:0] tx_byte;
        logic [5:0] rx_offset;
        logic [7:0] command_byte;
        logic [5:0] command_offset;
        logic       execute;
        logic [1:0] status;
        logic       last;
    } frame_descriptor_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic       in_valid = 1'b0;
    logic       in_ready;
    logic       cmd = scbs_pkg::CMD_WRITE;
    logic [5:0] byte_index = '0;
    logic [7:0] byte_value = '0;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic       cfg_data = scbs_pkg::MODE_INPUT;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic [5:0] channel;
    logic [7:0] tx_byte;
    logic [5:0] rx_offset;
    logic [7:0] command_byte;
    logic [5:0] command_offset;
    logic       execute;
    logic [1:0] status;
    logic       last;

    // Predictor state
    logic [7:0] command_ram [scbs_pkg::RAM_BYTES];
    logic       scan_mode_copy = scbs_pkg::MODE_INPUT;

    ram_request_t      pending_requests [$];
    frame_descriptor_t expected_descriptors [$];

    int  queued_items = 0;
    int  errors = 0;
    int  cycle_count = 0;
    int  sender_idle_pct = 0;
    int  receiver_stall_pct = 0;
    logic hold_phase = 1'b0;
    logic long_hold = 1'b0;

    serial_command_block_scanner_core uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .cmd            (cmd),
        .byte_index     (byte_index),
        .byte_value     (byte_value),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .channel        (channel),
        .tx_byte        (tx_byte),
        .rx_offset      (rx_offset),
        .command_byte   (command_byte),
        .command_offset (command_offset),
        .execute        (execute),
        .status         (status),
        .last           (last)
    );

    always #5 clk = ~clk;

    // Bytes skipped after the command offset; zero marks an unknown or reserved code
    function automatic int frame_span(input logic [7:0] cb);
        int span;
        case (cb)
            scbs_pkg::CB_RESET, scbs_pkg::CB_INFO, scbs_pkg::CB_STATUS: span = 4;
            scbs_pkg::CB_READ:                                          span = 5;
            scbs_pkg::CB_PAK_RD, scbs_pkg::CB_PAK_WR:                   span = 'h24;
            scbs_pkg::CB_EEP_RD, scbs_pkg::CB_EEP_WR:                   span = 'hA;
            scbs_pkg::CB_RTC_RD, scbs_pkg::CB_RTC_WR:                   span = 'hB;
            default:                                                    span = 0;
        endcase
        return span;
    endfunction

    function automatic frame_descriptor_t make_descriptor(input int ch, input logic [7:0] tx,
                                                          input int rxo, input logic [7:0] cb,
                                                          input int co, input logic ex,
                                                          input logic [1:0] st, input logic lst);
        frame_descriptor_t d;
        d.channel        = 6'(ch);
        d.tx_byte        = tx;
        d.rx_offset      = 6'(rxo);
        d.command_byte   = cb;
        d.command_offset = 6'(co);
        d.execute        = ex;
        d.status         = st;
        d.last           = lst;
        return d;
    endfunction

    // Apply one accepted request to the predictor and queue the descriptors it yields
    function automatic void apply_request(input ram_request_t req);
        int i;
        int ch;
        int n;
        int span;
        logic [1:0] st;
        logic [7:0] tx;
        logic [7:0] cb;
        logic ex;
        if (req.cmd == scbs_pkg::CMD_WRITE)
        begin
            command_ram[req.byte_index] = req.byte_value;
            return;
        end
        i = 0;
        ch = 0;
        n = 0;
        st = scbs_pkg::ST_END;
        while (1)
        begin
            if (i >= scbs_pkg::RAM_BYTES)
            begin
                st = scbs_pkg::ST_OVERRUN;
                break;
            end
            if (command_ram[i] == scbs_pkg::BYTE_END)
            begin
                st = scbs_pkg::ST_END;
                break;
            end
            if (i + 1 >= scbs_pkg::RAM_BYTES)
            begin
                st = scbs_pkg::ST_OVERRUN;
                break;
            end
            if (command_ram[i + 1] == scbs_pkg::BYTE_END)
            begin
                st = scbs_pkg::ST_END;
                break;
            end
            // skip pad bytes
            while (i < scbs_pkg::RAM_BYTES &&
                   (command_ram[i] == scbs_pkg::BYTE_PAD ||
                    command_ram[i] == scbs_pkg::BYTE_PAD_ALT))
                i++;
            if (i >= scbs_pkg::RAM_BYTES)
            begin
                st = scbs_pkg::ST_OVERRUN;
                break;
            end
            if (command_ram[i] == scbs_pkg::BYTE_END)
            begin
                st = scbs_pkg::ST_END;
                break;
            end
            tx = command_ram[i];
            i++;
            // a zero transmit byte only advances the channel
            if (tx == scbs_pkg::BYTE_SKIP)
            begin
                ch = (ch + 1) % 64;
                continue;
            end
            if (i + 1 >= scbs_pkg::RAM_BYTES)
            begin
                st = scbs_pkg::ST_OVERRUN;
                break;
            end
            cb = command_ram[i + 1];
            span = frame_span(cb);
            if (span == 0)
            begin
                expected_descriptors.push_back(
                    make_descriptor(ch, tx, i, cb, i + 1, 1'b0, scbs_pkg::ST_UNKNOWN, 1'b1));
                return;
            end
            if (n >= scbs_pkg::MAX_RESULTS - 1)
            begin
                st = scbs_pkg::ST_OVERRUN;
                break;
            end
            ex = (scan_mode_copy == scbs_pkg::MODE_INPUT) ? 1'b1 : (cb == scbs_pkg::CB_READ);
            expected_descriptors.push_back(
                make_descriptor(ch, tx, i, cb, i + 1, ex, scbs_pkg::ST_FRAME, 1'b0));
            n++;
            ch = (ch + 1) % 64;
            i = i + 1 + span;
        end
        if (st == scbs_pkg::ST_END)
            command_ram[scbs_pkg::RAM_BYTES - 1] = 8'h00;
        expected_descriptors.push_back(make_descriptor(ch, 8'h00, 0, 8'h00, 0, 1'b0, st, 1'b1));
    endfunction

    task automatic check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endtask

    task automatic queue_write(input logic [5:0] idx, input logic [7:0] val);
        ram_request_t req;
        req.cmd = scbs_pkg::CMD_WRITE;
        req.byte_index = idx;
        req.byte_value = val;
        pending_requests.push_back(req);
        queued_items++;
    endtask

    task automatic queue_scan();
        ram_request_t req;
        req.cmd = scbs_pkg::CMD_SCAN;
        req.byte_index = 6'($urandom);
        req.byte_value = 8'($urandom);
        pending_requests.push_back(req);
        queued_items++;
    endtask

    function automatic logic [7:0] random_command();
        logic [7:0] cb;
        if ($urandom_range(99) < 15)
            cb = 8'($urandom);
        else
            case ($urandom_range(9))
                0: cb = scbs_pkg::CB_INFO;
                1: cb = scbs_pkg::CB_READ;
                2: cb = scbs_pkg::CB_PAK_RD;
                3: cb = scbs_pkg::CB_PAK_WR;
                4: cb = scbs_pkg::CB_EEP_RD;
                5: cb = scbs_pkg::CB_EEP_WR;
                6: cb = scbs_pkg::CB_STATUS;
                7: cb = scbs_pkg::CB_RTC_RD;
                8: cb = scbs_pkg::CB_RTC_WR;
                default: cb = scbs_pkg::CB_RESET;
            endcase
        return cb;
    endfunction

    // Lay out a command block from offset 0, mostly well-formed, then scan it
    task automatic queue_command_block();
        int p;
        int frames;
        int k;
        int span;
        logic [7:0] tx;
        logic [7:0] rx;
        logic [7:0] cb;
        p = 0;
        frames = $urandom_range(1, 5);
        for (k = 0; k < frames; k++)
        begin
            if ($urandom_range(2) == 0)
            begin
                queue_write(6'(p),
                            $urandom_range(1) ? scbs_pkg::BYTE_PAD : scbs_pkg::BYTE_PAD_ALT);
                p++;
            end
            if ($urandom_range(3) == 0 && p < scbs_pkg::RAM_BYTES)
            begin
                queue_write(6'(p), scbs_pkg::BYTE_SKIP);
                p++;
            end
            if (p > scbs_pkg::RAM_BYTES - 3)
                break;
            tx = 8'($urandom_range(1, 252));
            rx = ($urandom_range(15) == 0) ? scbs_pkg::BYTE_END : 8'($urandom_range(255));
            cb = random_command();
            queue_write(6'(p), tx);
            queue_write(6'(p + 1), rx);
            queue_write(6'(p + 2), cb);
            span = frame_span(cb);
            if (span == 0)
                break;
            p = p + 2 + span;
            if (p >= scbs_pkg::RAM_BYTES)
                break;
        end
        if (p < scbs_pkg::RAM_BYTES && $urandom_range(9) != 0)
            queue_write(6'(p), scbs_pkg::BYTE_END);
        queue_scan();
    endtask

    // Mostly well-formed blocks, the rest stray byte loads and scans of whatever is stored
    task automatic queue_random(input int n_items);
        int target;
        int pick;
        target = queued_items + n_items;
        while (queued_items < target)
        begin
            pick = $urandom_range(99);
            if (pick < 75)
                queue_command_block();
            else if (pick < 92)
                repeat ($urandom_range(1, 4)) queue_write(6'($urandom), 8'($urandom));
            else
                queue_scan();
        end
    endtask

    // Hold until every request is taken and every descriptor is back, then let the block settle;
    // sample between edges so that requests offered at an edge are already visible
    task automatic wait_idle();
        while (pending_requests.size() != 0 || in_valid || expected_descriptors.size() != 0)
            @(negedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_mode(input logic mode);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= mode;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        scan_mode_copy = mode;
    endtask

    task automatic run_phase(input logic mode, input int idle_pct, input int stall_pct);
        wait_idle();
        write_mode(mode);
        sender_idle_pct = idle_pct;
        receiver_stall_pct = stall_pct;
        queue_random(PHASE_ITEMS);
    endtask

    // Offer the oldest pending request; predict it once accepted
    always @(posedge clk)
    begin : drive_requests
        ram_request_t req;
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                req.cmd = cmd;
                req.byte_index = byte_index;
                req.byte_value = byte_value;
                apply_request(req);
            end
            if (!in_valid || in_ready)
            begin
                if (pending_requests.size() != 0 && $urandom_range(99) >= sender_idle_pct)
                begin
                    req = pending_requests.pop_front();
                    in_valid <= 1'b1;
                    cmd <= req.cmd;
                    byte_index <= req.byte_index;
                    byte_value <= req.byte_value;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Compare each accepted descriptor with the oldest prediction
    always @(posedge clk)
    begin : watch_descriptors
        frame_descriptor_t want;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (expected_descriptors.size() == 0)
                begin
                    $error("descriptor with none expected: channel %0d status %0d",
                           channel, status);
                    errors++;
                end
                else
                begin
                    want = expected_descriptors.pop_front();
                    check_field("channel", want.channel, channel);
                    check_field("tx_byte", want.tx_byte, tx_byte);
                    check_field("rx_offset", want.rx_offset, rx_offset);
                    check_field("command_byte", want.command_byte, command_byte);
                    check_field("command_offset", want.command_offset, command_offset);
                    check_field("execute", want.execute, execute);
                    check_field("status", want.status, status);
                    check_field("last", want.last, last);
                end
            end
            out_ready <= !long_hold && ($urandom_range(99) >= receiver_stall_pct);
        end
    end

    // Hold off the receiver for a long stretch so the scan backs up into the input
    initial
    begin : receiver_hold
        wait (hold_phase);
        @(posedge clk);
        long_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        long_hold <= 1'b0;
    end

    // Abort a hung run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    initial
    begin : stimulus
        foreach (command_ram[j])
            command_ram[j] = 8'h00;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        write_mode(scbs_pkg::MODE_INPUT);

        // cleared RAM: zero transmit bytes walk to the end and overrun
        queue_scan();
        // end marker at offset 0
        queue_write(6'd0, scbs_pkg::BYTE_END);
        queue_scan();
        // both pad kinds, a skipped channel, then a read frame ending on a marker
        queue_write(6'd0, scbs_pkg::BYTE_PAD);
        queue_write(6'd1, scbs_pkg::BYTE_PAD_ALT);
        queue_write(6'd2, scbs_pkg::BYTE_SKIP);
        queue_write(6'd3, 8'h01);
        queue_write(6'd4, 8'h04);
        queue_write(6'd5, scbs_pkg::CB_READ);
        queue_write(6'd10, scbs_pkg::BYTE_END);
        queue_scan();
        // unknown command ends the scan
        queue_write(6'd5, CB_UNDEFINED);
        queue_scan();
        // short frame; the marker sits in the byte after the next index
        queue_write(6'd5, scbs_pkg::CB_RESET);
        queue_scan();
        // long frame lands on zeros; last byte set to all ones, run off the end
        queue_write(6'd5, scbs_pkg::CB_PAK_RD);
        queue_write(6'd63, 8'hFF);
        queue_scan();
        // normal end clears the last byte again
        queue_write(6'd5, scbs_pkg::CB_RESET);
        queue_write(6'd63, 8'hA5);
        queue_scan();

        run_phase(scbs_pkg::MODE_OUTPUT, 0, 0);
        run_phase(scbs_pkg::MODE_INPUT, 72, 0);
        run_phase(scbs_pkg::MODE_OUTPUT, 0, 72);
        run_phase(scbs_pkg::MODE_INPUT, 34, 34);
        run_phase(scbs_pkg::MODE_OUTPUT, 0, 0);
        hold_phase = 1'b1;

        wait_idle();
        repeat (50) @(posedge clk);
        if (expected_descriptors.size() != 0)
        begin
            $error("%0d descriptors never arrived", expected_descriptors.size());
            errors++;
        end
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
`default_nettype wire
